[design/gld_pkg.sv]
// gld_pkg: shared types and fixed constants of the grid local minimum detector
// used by gld_result_queue and grid_local_minimum_detector; depends on nothing
`timescale 1ns / 1ps

package gld_pkg;

   localparam int HEIGHT_W    = 4;
   localparam int COLS_REG_W  = 8;
   localparam int ROWS_REG_W  = 11;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 1;
   localparam int RESULT_SLOTS = 3;

   localparam logic [COLS_REG_W-1:0] COLS_RESET = 8'd128;
   localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 11'd1024;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_GRID_COLUMNS = 1'b0,
      REG_GRID_ROWS    = 1'b1
   } csr_index_type;

   // which of the three candidate cells of one item turned out to be low
   typedef struct packed {
      logic here;   // current cell, last row and last column
      logic left;   // last-row cell to the left of the current one
      logic above;  // cell above the current one
   } found_type;

endpackage

[design/gld_line_buffer.sv]
// gld_line_buffer: one-write two-read memory holding the two previous rows
// as {older, newer} height pairs per column; registered reads with write bypass
`timescale 1ns / 1ps

module gld_line_buffer #(
   parameter int DEPTH = 128,
   parameter int AW    = 7,
   parameter int DW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr0,
   input  logic [AW-1:0] rd_addr1,
   output logic [DW-1:0] rd_data0,
   output logic [DW-1:0] rd_data1
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd0_ff;
   logic [DW-1:0] rd1_ff;
   logic [DW-1:0] byp_data_ff;
   logic          hit0_ff;
   logic          hit1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd0_ff      <= mem[rd_addr0];
         rd1_ff      <= mem[rd_addr1];
         // a read that meets the write of the same edge sees the new data
         hit0_ff     <= wr_en && (wr_addr == rd_addr0);
         hit1_ff     <= wr_en && (wr_addr == rd_addr1);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data0 = hit0_ff ? byp_data_ff : rd0_ff;
   assign rd_data1 = hit1_ff ? byp_data_ff : rd1_ff;

endmodule

[design/gld_result_queue.sv]
// gld_result_queue: holds up to three results of one item and hands them out
// one per cycle while out_ready is high, lowest slot first; depends on gld_pkg
`timescale 1ns / 1ps

module gld_result_queue #(
   parameter int PW = 21
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load_valid,
   input  gld_pkg::found_type                     found,
   input  logic [gld_pkg::RESULT_SLOTS-1:0][PW-1:0] load_data,
   output logic                                   load_ready,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [PW-1:0]                          out_data,
   output logic                                   out_last
);

   logic [gld_pkg::RESULT_SLOTS-1:0]          slot_valid_ff;
   logic [gld_pkg::RESULT_SLOTS-1:0][PW-1:0] slot_data_ff;
   logic [1:0]                                head;
   logic                                      single;

   always_comb begin
      priority if (slot_valid_ff[0]) begin
         head = 2'd0;
      end else if (slot_valid_ff[1]) begin
         head = 2'd1;
      end else begin
         head = 2'd2;
      end
   end

   assign single = (slot_valid_ff == 3'b001) || (slot_valid_ff == 3'b010) ||
                   (slot_valid_ff == 3'b100);

   assign out_valid  = |slot_valid_ff;
   assign out_data   = slot_data_ff[head];
   assign out_last   = single;
   // the next item's results may come in as the last pending one leaves
   assign load_ready = (slot_valid_ff == '0) || (single && out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (load_valid) begin
         slot_valid_ff <= {found.here, found.left, found.above};
      end else if (out_valid && out_ready) begin
         // drop the lowest pending slot
         slot_valid_ff <= slot_valid_ff & (slot_valid_ff - 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid) begin
         slot_data_ff <= load_data;
      end
   end

endmodule

[design/grid_local_minimum_detector.sv]
// grid_local_minimum_detector: 4-neighbour low point detection on a raster
// height stream; uses gld_pkg, gld_line_buffer and gld_result_queue
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  req_height
//   rsp      out  rsp_valid/rsp_ready  rsp_low_height, rsp_low_row, rsp_low_column,
//                                      rsp_last_of_item
//   csr      in   csr_write_enable     csr_index, csr_write_data
//
// one item per cycle while the result queue can take results; an item passes the
// item register, then the result queue; an item giving two or three results (last
// row only) holds the input as the queue drains them, one per cycle with rsp_ready high
// line buffer reads of column c and c+1 are issued as the item is accepted
// synchronous reset clears counters, pixel history, config and queue; the
// line buffer is not cleared, and a value read before it is written goes unused
`timescale 1ns / 1ps

module grid_local_minimum_detector #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 1024,
   localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [gld_pkg::HEIGHT_W-1:0]         req_height,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [gld_pkg::HEIGHT_W-1:0]         rsp_low_height,
   output logic [RW-1:0]                        rsp_low_row,
   output logic [CW-1:0]                        rsp_low_column,
   output logic                                 rsp_last_of_item,
   input  logic                                 csr_write_enable,
   input  logic [gld_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gld_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam int HW = gld_pkg::HEIGHT_W;
   localparam int PW = HW + RW + CW;

   logic [gld_pkg::COLS_REG_W-1:0] grid_columns_ff;
   logic [gld_pkg::ROWS_REG_W-1:0] grid_rows_ff;
   logic [CW:0]                    eff_cols;
   logic [RW:0]                    eff_rows;

   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic          last_col_now;
   logic          last_row_now;
   logic          accept;

   logic          a_valid_ff;
   logic [HW-1:0] a_height_ff;
   logic [CW-1:0] a_col_ff;
   logic [RW-1:0] a_row_ff;
   logic          a_last_col_ff;
   logic          a_last_row_ff;
   logic          fire;
   logic          load_ready;

   logic [HW-1:0] prev_pixel_ff;
   logic [HW-1:0] sprev_pixel_ff;
   logic [HW-1:0] prev_v_ff;

   logic [2*HW-1:0] pair_c;
   logic [2*HW-1:0] pair_c1;
   logic [HW-1:0]   older_c;
   logic [HW-1:0]   newer_c;
   logic [HW-1:0]   newer_c1;
   logic [CW-1:0]   col_plus1;

   logic col_nz;
   logic col_ge2;
   logic row_nz;
   logic row_ge2;

   gld_pkg::found_type                         found;
   logic [gld_pkg::RESULT_SLOTS-1:0][PW-1:0]   cand;
   logic [PW-1:0]                              out_data;

   // out-of-range register values clamp to the legal range
   always_comb begin
      if (grid_columns_ff == '0) begin
         eff_cols = (CW+1)'(1);
      end else if (grid_columns_ff >= MAX_COLUMNS) begin
         eff_cols = (CW+1)'(MAX_COLUMNS);
      end else begin
         eff_cols = (CW+1)'(grid_columns_ff);
      end
      if (grid_rows_ff == '0) begin
         eff_rows = (RW+1)'(1);
      end else if (grid_rows_ff >= MAX_ROWS) begin
         eff_rows = (RW+1)'(MAX_ROWS);
      end else begin
         eff_rows = (RW+1)'(grid_rows_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= gld_pkg::COLS_RESET;
         grid_rows_ff    <= gld_pkg::ROWS_RESET;
      end else if (csr_write_enable) begin
         unique case (gld_pkg::csr_index_type'(csr_index))
            gld_pkg::REG_GRID_COLUMNS: begin
               grid_columns_ff <= csr_write_data[gld_pkg::COLS_REG_W-1:0];
            end
            gld_pkg::REG_GRID_ROWS: begin
               grid_rows_ff <= csr_write_data[gld_pkg::ROWS_REG_W-1:0];
            end
         endcase
      end
   end

   assign last_col_now = ({1'b0, col_ff} + 1'b1) >= eff_cols;
   assign last_row_now = ({1'b0, row_ff} + 1'b1) >= eff_rows;
   assign fire         = a_valid_ff && load_ready;
   assign req_ready    = !a_valid_ff || load_ready;
   assign accept       = req_valid && req_ready;

   // raster position of the next item, and the item register
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (last_col_now) begin
               col_ff <= '0;
               row_ff <= last_row_now ? '0 : row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
            a_valid_ff <= 1'b1;
         end else if (fire) begin
            a_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_height_ff   <= req_height;
         a_col_ff      <= col_ff;
         a_row_ff      <= row_ff;
         a_last_col_ff <= last_col_now;
         a_last_row_ff <= last_row_now;
      end
   end

   assign col_plus1 = col_ff + 1'b1;

   gld_line_buffer #(
      .DEPTH (MAX_COLUMNS),
      .AW    (CW),
      .DW    (2*HW)
   ) u_line_buffer (
      .clock    (clock),
      .wr_en    (fire),
      .wr_addr  (a_col_ff),
      .wr_data  ({newer_c, a_height_ff}),
      .rd_en    (accept),
      .rd_addr0 (col_ff),
      .rd_addr1 (col_plus1),
      .rd_data0 (pair_c),
      .rd_data1 (pair_c1)
   );

   assign older_c  = pair_c[2*HW-1:HW];
   assign newer_c  = pair_c[HW-1:0];
   assign newer_c1 = pair_c1[HW-1:0];

   assign col_nz  = a_col_ff != '0;
   assign col_ge2 = a_col_ff > CW'(1);
   assign row_nz  = a_row_ff != '0;
   assign row_ge2 = a_row_ff > RW'(1);

   // left neighbour of the upper cell and up neighbour of the left last-row
   // cell are both the previous item's newer-row value
   always_comb begin
      found.above = row_nz && (newer_c < a_height_ff) &&
                    (!col_nz || (newer_c < prev_v_ff)) &&
                    (a_last_col_ff || (newer_c < newer_c1)) &&
                    (!row_ge2 || (newer_c < older_c));
      found.left  = a_last_row_ff && col_nz && (prev_pixel_ff < a_height_ff) &&
                    (!col_ge2 || (prev_pixel_ff < sprev_pixel_ff)) &&
                    (!row_nz || (prev_pixel_ff < prev_v_ff));
      found.here  = a_last_row_ff && a_last_col_ff &&
                    (!col_nz || (a_height_ff < prev_pixel_ff)) &&
                    (!row_nz || (a_height_ff < newer_c));
      cand[0] = {newer_c, a_row_ff - 1'b1, a_col_ff};
      cand[1] = {prev_pixel_ff, a_row_ff, a_col_ff - 1'b1};
      cand[2] = {a_height_ff, a_row_ff, a_col_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pixel_ff  <= '0;
         sprev_pixel_ff <= '0;
      end else if (fire) begin
         prev_pixel_ff  <= a_height_ff;
         sprev_pixel_ff <= prev_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         prev_v_ff <= newer_c;
      end
   end

   gld_result_queue #(
      .PW (PW)
   ) u_result_queue (
      .clock      (clock),
      .reset      (reset),
      .load_valid (fire),
      .found      (found),
      .load_data  (cand),
      .load_ready (load_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data),
      .out_last   (rsp_last_of_item)
   );

   assign rsp_low_height = out_data[PW-1:RW+CW];
   assign rsp_low_row    = out_data[RW+CW-1:CW];
   assign rsp_low_column = out_data[CW-1:0];

endmodule
